// ----- rtl/gww_pkg.sv -----
// Shared types and constants for the greedy word wrap unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package gww_pkg;

	localparam int DefMaxWord  = 32;
	localparam int DefMaxWidth = 32;
	localparam int CfgW        = 6;
	localparam int CharW       = 8;
	localparam int OutDataW    = 16;
	localparam logic [CfgW-1:0]  WidthReset = 6'd32;
	localparam logic [CharW-1:0] SpaceChar  = 8'd32;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_EOL  = 2'd1,
		KIND_EOT  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_BREAK,
		ST_SPACE,
		ST_WORD,
		ST_EOL,
		ST_EOT
	} state_t;

	typedef enum logic [1:0] {
		SEL_SPACE,
		SEL_WORD,
		SEL_EOL,
		SEL_EOT
	} out_sel_t;

	typedef struct packed {
		logic     accept;
		logic     decide;
		logic     emit;
		out_sel_t sel;
	} gww_cmd_t;

	typedef struct packed {
		logic flush;
		logic brk;
		logic sp_nz;
		logic sp_last;
		logic word_last;
		logic line_nz;
		logic eot;
		logic out_free;
	} gww_status_t;

endpackage

// ----- rtl/greedy_word_wrap_unit.sv -----
// Top level of the greedy word wrap unit.
// Depends on gww_pkg, gww_ctrl, gww_dp and gww_ram.
//
// Usage: characters enter one beat at a time on the s_axis channel, tdata[7:0]
// carrying the byte and tlast marking the final character of a text. Byte 32 is
// a space, every other byte is a word character. Results leave on m_axis, one
// beat per emitted character, line end or text end; tuser carries the kind and
// tlast marks the last beat caused by one input character. Line width is set
// through cfg_we/cfg_wdata while the unit is idle; zero acts as one.
// Timing: an input beat is taken only when the controller is idle. Every input
// passes through the decision state; a character that ends no word and no text
// then returns to idle. A finished word is replayed from the word RAM at one
// character per cycle while the receiver does not stall, preceded by its spaces
// or a line end. After the decision state, the first result of a beat is loaded
// into the output register by the state that emits it.
// The output is a single register: if the receiver stalls, replay pauses with
// it, while the next input beat is still taken once the controller is idle.
// Reset clears all counters and the sticky truncation flag and sets the width
// to 32; the word RAM is not cleared, since only written entries are read.
module greedy_word_wrap_unit #(
	parameter int MAX_WORD  = gww_pkg::DefMaxWord,
	parameter int MAX_WIDTH = gww_pkg::DefMaxWidth
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gww_pkg::CfgW-1:0]     cfg_wdata,      // wrap width
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [gww_pkg::CharW-1:0]    s_axis_tdata,   // ch
	input  logic                         s_axis_tlast,   // end_of_text
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [gww_pkg::OutDataW-1:0] m_axis_tdata,   // out_char[7:0], word_truncated[8]
	output logic [1:0]                   m_axis_tuser,   // kind
	output logic                         m_axis_tlast    // last
);
	import gww_pkg::*;

	gww_cmd_t    cmd;
	gww_status_t st;

	// The controller sequences decision, line break, spaces and word replay.
	gww_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.st      (st),
		.cmd     (cmd)
	);

	// The datapath holds the counters, the word buffer and the output beat.
	gww_dp #(
		.MAX_WORD  (MAX_WORD),
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_char   (s_axis_tdata),
		.in_eot    (s_axis_tlast),
		.cmd       (cmd),
		.st        (st),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata),
		.m_kind    (m_axis_tuser),
		.m_last    (m_axis_tlast)
	);

endmodule

// ----- rtl/gww_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the current word; no dependencies.
module gww_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/gww_ctrl.sv -----
// Controller state machine of the greedy word wrap unit.
// Depends on gww_pkg; drives the datapath through gww_cmd_t.
module gww_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_valid,
	output logic                 s_ready,
	input  gww_pkg::gww_status_t st,
	output gww_pkg::gww_cmd_t    cmd
);
	import gww_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (st.flush) begin
					if (st.brk) state_d = ST_BREAK;
					else if (st.sp_nz) state_d = ST_SPACE;
					else state_d = ST_WORD;
				end else if (st.eot) begin
					state_d = st.line_nz ? ST_EOL : ST_EOT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_BREAK: begin
				if (st.out_free) state_d = ST_WORD;
			end
			ST_SPACE: begin
				if (st.out_free && st.sp_last) state_d = ST_WORD;
			end
			ST_WORD: begin
				if (st.out_free && st.word_last) begin
					if (st.eot) state_d = st.line_nz ? ST_EOL : ST_EOT;
					else state_d = ST_IDLE;
				end
			end
			ST_EOL: begin
				if (st.out_free) state_d = ST_EOT;
			end
			ST_EOT: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_ready    = 1'b0;
		cmd.accept = 1'b0;
		cmd.decide = 1'b0;
		cmd.emit   = 1'b0;
		cmd.sel    = SEL_EOL;
		case (state_q)
			ST_IDLE: begin
				s_ready    = 1'b1;
				cmd.accept = s_valid;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			ST_BREAK: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_EOL;
			end
			ST_SPACE: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_SPACE;
			end
			ST_WORD: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_WORD;
			end
			ST_EOL: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_EOL;
			end
			ST_EOT: begin
				cmd.emit = st.out_free;
				cmd.sel  = SEL_EOT;
			end
			default: begin
				s_ready = 1'b0;
			end
		endcase
	end

	// A beat is only loaded into the output register when the slot is free.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("emit while output register is occupied");

	// The final character of a word ends the item when no end of text follows.
	a_word_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WORD && st.out_free && st.word_last && !st.eot)
		|=> state_q == ST_IDLE)
		else $error("word replay did not return to idle");

endmodule

// ----- rtl/gww_dp.sv -----
// Datapath of the greedy word wrap unit: counters, word buffer and output register.
// Depends on gww_pkg and gww_ram; steered by gww_ctrl through gww_cmd_t.
module gww_dp #(
	parameter int MAX_WORD  = gww_pkg::DefMaxWord,
	parameter int MAX_WIDTH = gww_pkg::DefMaxWidth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gww_pkg::CfgW-1:0]      cfg_wdata,
	input  logic [gww_pkg::CharW-1:0]     in_char,
	input  logic                          in_eot,
	input  gww_pkg::gww_cmd_t             cmd,
	output gww_pkg::gww_status_t          st,
	output logic                          m_valid,
	input  logic                          m_ready,
	output logic [gww_pkg::OutDataW-1:0]  m_data,
	output logic [1:0]                    m_kind,
	output logic                          m_last
);
	import gww_pkg::*;

	localparam int AW    = $clog2(MAX_WORD);
	localparam int WLW   = $clog2(MAX_WORD + 1);
	localparam int PSW   = $clog2(MAX_WIDTH + 1);
	localparam int LMAX  = (MAX_WORD > MAX_WIDTH) ? MAX_WORD : MAX_WIDTH;
	localparam int LLW   = $clog2(LMAX + 1);
	localparam int SUMW  = LLW + 2;
	localparam int EW    = (SUMW > CfgW) ? SUMW : CfgW;

	logic [CfgW-1:0]  width_q;
	logic [WLW-1:0]   wl_q;
	logic [PSW-1:0]   pend_q;
	logic [LLW-1:0]   line_q;
	logic             trunc_q;
	logic             space_q;
	logic             eot_q;
	logic [PSW-1:0]   sp_cnt_q;
	logic [AW-1:0]    rd_idx_q;
	logic             m_valid_q;
	kind_t            m_kind_q;
	logic [CharW-1:0] m_char_q;
	logic             m_trunc_q;
	logic             m_last_q;

	logic             in_space;
	logic             ram_we;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [CharW-1:0] ram_rdata;
	logic [EW-1:0]    eff_w;
	logic [EW-1:0]    need_sum;
	logic [EW-1:0]    fit_sum;
	logic [PSW-1:0]   sp;
	logic [PSW-1:0]   pend_base;
	logic             flush;
	logic             brk;
	logic             line_nz;
	logic             word_last;
	logic             out_free;
	logic             emit_word;
	kind_t            next_kind;
	logic [CharW-1:0] next_char;
	logic             next_last;

	assign in_space = (in_char == SpaceChar);
	assign ram_we   = cmd.accept && !in_space && (wl_q < WLW'(MAX_WORD));
	assign emit_word = cmd.emit && (cmd.sel == SEL_WORD);
	assign ram_re    = cmd.decide || emit_word;
	assign ram_raddr = cmd.decide ? '0 : rd_idx_q + AW'(1);

	gww_ram #(
		.WIDTH (CharW),
		.DEPTH (MAX_WORD)
	) u_word_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wl_q[AW-1:0]),
		.wdata (in_char),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Register value zero acts as one; values above the limit are clamped.
	always_comb begin
		if (width_q == '0) eff_w = EW'(1);
		else if (EW'(width_q) > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
		else eff_w = EW'(width_q);
	end

	assign line_nz  = (line_q != '0);
	assign flush    = (space_q || eot_q) && (wl_q != '0);
	assign need_sum = EW'(line_q) + EW'(pend_q) + EW'(wl_q);
	assign brk      = line_nz && (need_sum > eff_w);
	assign sp       = (brk || !line_nz) ? '0 : pend_q;
	assign fit_sum  = EW'(line_q) + EW'(sp) + EW'(wl_q);
	assign pend_base = flush ? '0 : pend_q;
	assign word_last = (WLW'(rd_idx_q) + WLW'(1)) == wl_q;
	assign out_free  = !m_valid_q || m_ready;

	always_comb begin
		st.flush     = flush;
		st.brk       = brk;
		st.sp_nz     = (sp != '0);
		st.sp_last   = (sp_cnt_q == PSW'(1));
		st.word_last = word_last;
		st.line_nz   = line_nz;
		st.eot       = eot_q;
		st.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WidthReset;
			wl_q      <= '0;
			pend_q    <= '0;
			line_q    <= '0;
			trunc_q   <= 1'b0;
			space_q   <= 1'b0;
			eot_q     <= 1'b0;
			sp_cnt_q  <= '0;
			rd_idx_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				width_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				space_q <= in_space;
				eot_q   <= in_eot;
				if (!in_space) begin
					if (wl_q < WLW'(MAX_WORD)) wl_q <= wl_q + WLW'(1);
					else trunc_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				rd_idx_q <= '0;
				sp_cnt_q <= sp;
				if (flush) begin
					line_q <= brk ? LLW'(wl_q) : LLW'(fit_sum);
				end
				if (space_q) begin
					pend_q <= (pend_base < PSW'(MAX_WIDTH)) ? pend_base + PSW'(1) : pend_base;
				end else begin
					pend_q <= pend_base;
				end
			end
			if (cmd.emit) begin
				case (cmd.sel)
					SEL_SPACE: begin
						sp_cnt_q <= sp_cnt_q - PSW'(1);
					end
					SEL_WORD: begin
						rd_idx_q <= rd_idx_q + AW'(1);
						if (word_last) wl_q <= '0;
					end
					SEL_EOT: begin
						wl_q    <= '0;
						pend_q  <= '0;
						line_q  <= '0;
						trunc_q <= 1'b0;
					end
					default: begin
						line_q <= line_q;
					end
				endcase
			end
			if (cmd.emit) m_valid_q <= 1'b1;
			else if (m_ready) m_valid_q <= 1'b0;
		end
	end

	always_comb begin
		next_kind = KIND_EOL;
		next_char = '0;
		next_last = 1'b0;
		case (cmd.sel)
			SEL_SPACE: begin
				next_kind = KIND_CHAR;
				next_char = SpaceChar;
			end
			SEL_WORD: begin
				next_kind = KIND_CHAR;
				next_char = ram_rdata;
				next_last = word_last && !eot_q;
			end
			SEL_EOL: begin
				next_kind = KIND_EOL;
			end
			SEL_EOT: begin
				next_kind = KIND_EOT;
				next_last = 1'b1;
			end
			default: begin
				next_kind = KIND_EOL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_kind_q  <= next_kind;
			m_char_q  <= next_char;
			m_trunc_q <= trunc_q;
			m_last_q  <= next_last;
		end
	end

	assign m_valid = m_valid_q;
	assign m_data  = {{(OutDataW - CharW - 1){1'b0}}, m_trunc_q, m_char_q};
	assign m_kind  = m_kind_q;
	assign m_last  = m_last_q;

	a_wl_range: assert property (@(posedge clk) disable iff (!arst_n)
		wl_q <= WLW'(MAX_WORD))
		else $error("word length beyond buffer depth");

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PSW'(MAX_WIDTH))
		else $error("pending spaces beyond saturation");

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.sel == SEL_EOT)
		|=> (line_q == '0 && wl_q == '0 && pend_q == '0 && !trunc_q))
		else $error("text state not cleared after end of text");

endmodule

// ----- tb/greedy_word_wrap_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for greedy_word_wrap_unit: directed table, then random texts.
// Depends on gww_pkg and the unit; it keeps its own line-wrap predictor and result queue.
module greedy_word_wrap_unit_test;
	import gww_pkg::*;

	localparam int WORD_CAP  = DefMaxWord;
	localparam int WIDTH_CAP = DefMaxWidth;
	// Cycles of quiet before a width write, and after the last result at the end.
	localparam int IDLE_PAD    = 16;
	localparam int LONG_HOLD   = 400;
	localparam int RAND_TARGET = 88;

	localparam logic ROW_TEXT = 1'b0;
	localparam logic ROW_CFG  = 1'b1;

	// One result beat as the unit should present it.
	typedef struct {
		kind_t      kind;
		logic [7:0] ch;
		logic       trunc;
		logic       last;
	} wrap_beat_t;

	// One row of the directed table: a character or a width write. Where the first
	// result is obvious, it is typed in and cross-checked against the predictor.
	typedef struct packed {
		logic       row_kind;
		logic [7:0] val;
		logic       eot;
		logic       typed;
		kind_t      t_kind;
		logic [7:0] t_char;
	} stim_row_t;

	localparam int DIR_ROWS = 23;
	stim_row_t dir_tab [DIR_ROWS] = '{
		// A text made only of a space yields just the end of text.
		'{ROW_TEXT, 8'h20, 1'b1, 1'b1, KIND_EOT,  8'h00},
		// Byte zero is an ordinary word character.
		'{ROW_TEXT, 8'h00, 1'b1, 1'b1, KIND_CHAR, 8'h00},
		// Leading space dropped, then the all-ones byte as a word.
		'{ROW_TEXT, 8'h20, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'hFF, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h20, 1'b0, 1'b1, KIND_CHAR, 8'hFF},
		// Text ends on a space: the open word is flushed with its one space.
		'{ROW_TEXT, 8'h7F, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h20, 1'b1, 1'b1, KIND_CHAR, 8'h20},
		// Width 3: "ab  cd" must break before "cd" and drop the two spaces.
		'{ROW_CFG,  8'd3,  1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h61, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h62, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h20, 1'b0, 1'b1, KIND_CHAR, 8'h61},
		'{ROW_TEXT, 8'h20, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h63, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h64, 1'b1, 1'b1, KIND_EOL,  8'h00},
		// Width zero acts as one; the first word overruns without an empty line.
		'{ROW_CFG,  8'd0,  1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h78, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h79, 1'b1, 1'b1, KIND_CHAR, 8'h78},
		// Width 63 is clamped to the maximum line width.
		'{ROW_CFG,  8'd63, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h20, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h71, 1'b0, 1'b0, KIND_CHAR, 8'h00},
		'{ROW_TEXT, 8'h20, 1'b0, 1'b1, KIND_CHAR, 8'h71},
		'{ROW_TEXT, 8'h72, 1'b1, 1'b1, KIND_CHAR, 8'h20},
		'{ROW_CFG,  8'd32, 1'b0, 1'b0, KIND_CHAR, 8'h00}
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgW-1:0]     cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic [CharW-1:0]    s_tdata   = '0;
	logic                s_tlast   = 1'b0;
	logic                m_tready  = 1'b0;
	logic                s_axis_tready;
	logic                m_axis_tvalid;
	logic [OutDataW-1:0] m_axis_tdata;
	logic [1:0]          m_axis_tuser;
	logic                m_axis_tlast;

	// Predictor state: the width register and the wrap state of the current text.
	logic [CfgW-1:0] wrap_width_set = WidthReset;
	logic [7:0]      word_chars [WORD_CAP];
	int              word_len     = 0;
	int              spaces_held  = 0;
	int              line_len     = 0;
	logic            trunc_sticky = 1'b0;

	wrap_beat_t step_beats [$];   // results of the character just accepted
	wrap_beat_t wrapped_q  [$];   // results still owed by the unit

	int   errors      = 0;
	int   chars_sent  = 0;
	int   beats_seen  = 0;
	int   texts_sent  = 0;
	int   widths_set  = 0;
	bit   calm_tx     = 1'b0;
	bit   calm_rx     = 1'b0;
	bit   pressure_arm = 1'b0;
	bit   held_long   = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	greedy_word_wrap_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Wait time for one handshake. Now and then a side flips into a calm mode where
	// it never waits, so both back-to-back stretches and scattered gaps occur.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 15) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic void add_beat(kind_t k, logic [7:0] c);
		wrap_beat_t b;
		b.kind  = k;
		b.ch    = c;
		b.trunc = trunc_sticky;
		b.last  = 1'b0;
		step_beats.push_back(b);
	endfunction

	// Put the buffered word on the line. Its spaces come along only if the
	// whole thing fits; otherwise the line is closed first and they are lost.
	function automatic void place_word();
		int sp;
		int lim;
		if (word_len == 0)
			return;
		lim = (wrap_width_set == 0) ? 1 :
			(wrap_width_set > WIDTH_CAP) ? WIDTH_CAP : int'(wrap_width_set);
		sp = (line_len == 0) ? 0 : spaces_held;
		if (line_len > 0 && line_len + sp + word_len > lim) begin
			add_beat(KIND_EOL, 8'h00);
			line_len = 0;
			sp = 0;
		end
		repeat (sp)
			add_beat(KIND_CHAR, SpaceChar);
		for (int i = 0; i < word_len; i++)
			add_beat(KIND_CHAR, word_chars[i]);
		line_len += sp + word_len;
		spaces_held = 0;
		word_len = 0;
	endfunction

	// Work out what the unit must emit for one accepted character.
	function automatic void wrap_char(logic [7:0] c, logic eot);
		step_beats.delete();
		if (c == SpaceChar) begin
			place_word();
			if (spaces_held < WIDTH_CAP)
				spaces_held++;
		end else if (word_len < WORD_CAP) begin
			word_chars[word_len] = c;
			word_len++;
		end else begin
			trunc_sticky = 1'b1;
		end
		if (eot) begin
			place_word();
			if (line_len > 0)
				add_beat(KIND_EOL, 8'h00);
			add_beat(KIND_EOT, 8'h00);
			word_len = 0;
			spaces_held = 0;
			line_len = 0;
			trunc_sticky = 1'b0;
		end
		if (step_beats.size() > 0)
			step_beats[step_beats.size() - 1].last = 1'b1;
		foreach (step_beats[i])
			wrapped_q.push_back(step_beats[i]);
	endfunction

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == SpaceChar);
		return b;
	endfunction

	// Widths lean toward narrow lines so that breaks happen often.
	function automatic logic [CfgW-1:0] pick_width();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return 6'd1;
			end
			2: begin
				return CfgW'(WIDTH_CAP);
			end
			3: begin
				return 6'd63;
			end
			4, 5, 6: begin
				return CfgW'($urandom_range(2, 12));
			end
			default: begin
				return CfgW'($urandom_range(1, 32));
			end
		endcase
	endfunction

	// Offer one character and hold it until the unit takes it. A zero wait keeps
	// tvalid high into the next beat, so it is never dropped and raised in one step.
	task automatic feed_char(input logic [7:0] c, input logic eot);
		int gap;
		gap = draw_wait(calm_tx);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eot;
		do
			@(posedge clk);
		while (!s_axis_tready);
		wrap_char(c, eot);
		chars_sent++;
	endtask

	// The width may only change while the unit is idle: every owed result must be
	// out, and a character that produced nothing may still sit in its decide cycle.
	task automatic program_width(input logic [CfgW-1:0] w);
		s_tvalid <= 1'b0;
		while (wrapped_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		wrap_width_set = w;
		widths_set++;
	endtask

	// Compare one output beat against the oldest owed result.
	function automatic void check_beat();
		wrap_beat_t want;
		if (wrapped_q.size() == 0) begin
			$error("unexpected beat: kind %0d, out_char 0x%02h", m_axis_tuser,
				m_axis_tdata[7:0]);
			errors++;
			return;
		end
		want = wrapped_q.pop_front();
		if (m_axis_tuser !== want.kind) begin
			$error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
			errors++;
		end
		if (m_axis_tdata[7:0] !== want.ch) begin
			$error("out_char: expected 0x%02h, actual 0x%02h", want.ch, m_axis_tdata[7:0]);
			errors++;
		end
		if (m_axis_tdata[8] !== want.trunc) begin
			$error("word_truncated: expected %0b, actual %0b", want.trunc, m_axis_tdata[8]);
			errors++;
		end
		if (m_axis_tdata[OutDataW-1:9] !== '0) begin
			$error("tdata padding: expected 0, actual 0x%0h", m_axis_tdata[OutDataW-1:9]);
			errors++;
		end
		if (m_axis_tlast !== want.last) begin
			$error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
			errors++;
		end
	endfunction

	// Values read at the edge are those from before it, so the handshake seen
	// here is exactly the one the unit sees.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_tready) begin
			check_beat();
			beats_seen++;
		end
	end

	// Receiver. It stalls a random number of cycles before each beat; once, while a
	// long text is being fed, it holds off long enough that the unit backs up.
	initial begin : result_sink
		int pause;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pause = draw_wait(calm_rx);
			if (pressure_arm && !held_long) begin
				held_long = 1'b1;
				pause = LONG_HOLD;
			end
			if (pause > 0) begin
				m_tready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
		end
	end

	// Main sequence: reset, directed table, random texts, drain.
	initial begin : text_source
		logic [7:0] text_q [$];
		int         rand_chars;
		int         n_words;
		int         n_sp;
		int         w_len;
		int         n;
		bit         forced;
		rand_chars = 0;
		forced = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r]) begin
			if (dir_tab[r].row_kind == ROW_CFG) begin
				program_width(dir_tab[r].val[CfgW-1:0]);
			end else begin
				feed_char(dir_tab[r].val, dir_tab[r].eot);
				if (dir_tab[r].typed && (step_beats.size() == 0 ||
						step_beats[0].kind != dir_tab[r].t_kind ||
						step_beats[0].ch != dir_tab[r].t_char)) begin
					$error("table row %0d: first result should be kind %0d, char 0x%02h",
						r, dir_tab[r].t_kind, dir_tab[r].t_char);
					errors++;
				end
			end
		end
		texts_sent = 6;

		// Random texts. The first one is fixed in shape: a word longer than the
		// buffer and a space run past saturation. It is also where the receiver
		// takes its long hold. Later texts are mostly words, sometimes noise.
		while (rand_chars < RAND_TARGET) begin
			if (!forced && $urandom_range(0, 3) == 0)
				program_width(pick_width());
			text_q.delete();
			if (!forced && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 10);
				repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				n_words = forced ? 3 : $urandom_range(1, 6);
				for (int w = 0; w < n_words; w++) begin
					n_sp = (w == 0) ? $urandom_range(0, 1) : $urandom_range(1, 3);
					if ($urandom_range(0, 11) == 0)
						n_sp = $urandom_range(4, 36);
					w_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 36) :
						$urandom_range(1, 8);
					if (forced && w == 0)
						w_len = WORD_CAP + 1;
					if (forced && w == 1)
						n_sp = WIDTH_CAP + 1;
					repeat (n_sp) text_q.push_back(SpaceChar);
					repeat (w_len) text_q.push_back(word_byte());
				end
				if ($urandom_range(0, 3) == 0) begin
					n = $urandom_range(1, 3);
					repeat (n) text_q.push_back(SpaceChar);
				end
			end
			if (forced)
				pressure_arm = 1'b1;
			foreach (text_q[i])
				feed_char(text_q[i], i == text_q.size() - 1);
			rand_chars += text_q.size();
			texts_sent++;
			forced = 1'b0;
		end

		s_tvalid <= 1'b0;
		while (wrapped_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
		$display("Fed %0d characters in %0d texts over %0d width writes;", chars_sent,
			texts_sent, widths_set);
		$display("checked %0d result beats, including one long output stall.", beats_seen);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, even with every character causing
	// its most results and every beat waiting the longest stall.
	initial begin : watchdog
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
